[hdl/cfp_pkg.sv]
// Types, character codes and status codes shared by the coordinate frame parser.
package cfp_pkg;

	localparam int unsigned MaxFrameLenDefault = 32;

	localparam logic [7:0] ChrStart  = 8'h24;
	localparam logic [7:0] ChrEnd    = 8'h21;
	localparam logic [7:0] ChrSpace  = 8'h20;
	localparam logic [7:0] ChrMinus  = 8'h2D;
	localparam logic [7:0] ChrPoint  = 8'h2E;
	localparam logic [7:0] ChrZero   = 8'h30;
	localparam logic [7:0] ChrNine   = 8'h39;

	localparam int unsigned AccW = 14;
	localparam int unsigned ElW  = 15;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOSTART = 2'd1,
		ST_BAD     = 2'd2,
		ST_LONG    = 2'd3
	} status_t;

	typedef enum logic [7:0] {
		PH_START   = 8'b0000_0001,
		PH_AZ_INT  = 8'b0000_0010,
		PH_AZ_FRAC = 8'b0000_0100,
		PH_SEP     = 8'b0000_1000,
		PH_EL_INT  = 8'b0001_0000,
		PH_EL_FRAC = 8'b0010_0000,
		PH_END     = 8'b0100_0000,
		PH_ERROR   = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		phase_t              phase;
		logic [AccW-1:0]     az_acc;
		logic [AccW-1:0]     el_acc;
		logic                el_neg;
		logic [1:0]          digits;
		status_t             err;
	} parse_state_t;

	typedef struct packed {
		logic                   valid;
		status_t                status;
		logic [AccW-1:0]        azimuth;
		logic signed [ElW-1:0]  elevation;
	} parse_result_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= ChrZero) && (c <= ChrNine);
	endfunction

	function automatic logic [AccW-1:0] mac10(input logic [AccW-1:0] acc, input logic [7:0] c);
		logic [7:0] d;
		d = c - ChrZero;
		return (acc << 3) + (acc << 1) + AccW'(d[3:0]);
	endfunction

endpackage

[hdl/coordinate_frame_text_parser_top.sv]
// Top level of the coordinate frame parser: input register, parse state and result register.
//
//   channel   ports                                                 direction
//   input     in_valid, in_ready, rx_byte                           into block
//   result    out_valid, out_ready, frame_status, azimuth_tenths,   out of block
//             elevation_tenths
//
// One byte a cycle is taken while the result side does not stall; the result of a closing byte
// passes from the input register through the single parse step into the result register.
// Reset clears the parse state at once; no clearing pass is needed.
// A result waiting on out_ready stalls the parse step; input stops once byte_s1 is full.
module coordinate_frame_text_parser_top import cfp_pkg::*; #(
	parameter int unsigned MAX_FRAME_LEN = MaxFrameLenDefault
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             rx_byte,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             frame_status,
	output logic [AccW-1:0]        azimuth_tenths,
	output logic signed [ElW-1:0]  elevation_tenths
);

	localparam int unsigned LenW = $clog2(MAX_FRAME_LEN + 1);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	parse_state_t    state_q;
	logic [LenW-1:0] len_q;
	parse_state_t    state_nxt;
	logic [LenW-1:0] len_nxt;
	parse_result_t   res;
	logic            out_valid_q;
	status_t         status_q;
	logic [AccW-1:0] az_q;
	logic signed [ElW-1:0] el_q;
	logic            out_free;
	logic            step;

	assign out_free = !out_valid_q || out_ready;
	assign step     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	cfp_parse_core #(
		.MAX_FRAME_LEN(MAX_FRAME_LEN)
	) u_core (
		.rx_byte(byte_s1),
		.cur(state_q),
		.len_cur(len_q),
		.nxt(state_nxt),
		.len_nxt(len_nxt),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '{phase: PH_START, err: ST_OK, default: '0};
			len_q       <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (step) begin
				state_q <= state_nxt;
				len_q   <= len_nxt;
			end
			if (out_free) begin
				out_valid_q <= step && res.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
		if (step && res.valid) begin
			status_q <= res.status;
			az_q     <= res.azimuth;
			el_q     <= res.elevation;
		end
	end

	assign out_valid        = out_valid_q;
	assign frame_status     = status_q;
	assign azimuth_tenths   = az_q;
	assign elevation_tenths = el_q;

endmodule

[hdl/cfp_parse_core.sv]
// Next-state and result logic of the frame parser for one received byte.
module cfp_parse_core import cfp_pkg::*; #(
	parameter int unsigned MAX_FRAME_LEN = MaxFrameLenDefault,
	localparam int unsigned LenW = $clog2(MAX_FRAME_LEN + 1)
) (
	input  logic [7:0]      rx_byte,
	input  parse_state_t    cur,
	input  logic [LenW-1:0] len_cur,
	output parse_state_t    nxt,
	output logic [LenW-1:0] len_nxt,
	output parse_result_t   res
);

	localparam logic [LenW-1:0] LenMax = LenW'(MAX_FRAME_LEN);

	logic [LenW-1:0] len_inc;
	logic            fail;
	status_t         fail_code;

	always_comb begin
		nxt       = cur;
		len_nxt   = len_cur;
		fail      = 1'b0;
		fail_code = ST_BAD;
		res       = '0;
		len_inc   = (len_cur < LenMax) ? len_cur + LenW'(1) : len_cur;
		if (rx_byte == ChrEnd) begin
			res.valid = 1'b1;
			unique case (cur.phase)
				PH_END: begin
					res.status    = ST_OK;
					res.azimuth   = cur.az_acc;
					res.elevation = cur.el_neg ? -$signed({1'b0, cur.el_acc})
					                           : $signed({1'b0, cur.el_acc});
				end
				PH_ERROR: res.status = cur.err;
				PH_START: res.status = ST_NOSTART;
				default:  res.status = ST_BAD;
			endcase
			nxt     = '{phase: PH_START, err: ST_OK, default: '0};
			len_nxt = '0;
		end else begin
			len_nxt = len_inc;
			if (len_inc >= LenMax) begin
				nxt.err   = ST_LONG;
				nxt.phase = PH_ERROR;
			end else begin
				unique case (cur.phase)
					PH_START: begin
						if (rx_byte == ChrStart) begin
							nxt.phase  = PH_AZ_INT;
							nxt.digits = '0;
						end else begin
							fail      = 1'b1;
							fail_code = ST_NOSTART;
						end
					end
					PH_AZ_INT: begin
						if (rx_byte == ChrPoint && cur.digits != 2'd0) begin
							nxt.phase = PH_AZ_FRAC;
						end else if (is_digit(rx_byte) && cur.digits != 2'd3) begin
							nxt.az_acc = mac10(cur.az_acc, rx_byte);
							nxt.digits = cur.digits + 2'd1;
						end else begin
							fail = 1'b1;
						end
					end
					PH_AZ_FRAC: begin
						if (is_digit(rx_byte)) begin
							nxt.az_acc = mac10(cur.az_acc, rx_byte);
							nxt.phase  = PH_SEP;
						end else begin
							fail = 1'b1;
						end
					end
					PH_SEP: begin
						if (rx_byte == ChrSpace) begin
							nxt.phase  = PH_EL_INT;
							nxt.digits = '0;
						end else begin
							fail = 1'b1;
						end
					end
					PH_EL_INT: begin
						if (rx_byte == ChrMinus && cur.digits == 2'd0 && !cur.el_neg) begin
							nxt.el_neg = 1'b1;
						end else if (rx_byte == ChrPoint && cur.digits != 2'd0) begin
							nxt.phase = PH_EL_FRAC;
						end else if (is_digit(rx_byte) && cur.digits != 2'd3) begin
							nxt.el_acc = mac10(cur.el_acc, rx_byte);
							nxt.digits = cur.digits + 2'd1;
						end else begin
							fail = 1'b1;
						end
					end
					PH_EL_FRAC: begin
						if (is_digit(rx_byte)) begin
							nxt.el_acc = mac10(cur.el_acc, rx_byte);
							nxt.phase  = PH_END;
						end else begin
							fail = 1'b1;
						end
					end
					PH_END:   fail = 1'b1;
					PH_ERROR: ;
					default:  ;
				endcase
				if (fail) begin
					nxt.phase = PH_ERROR;
					if (cur.err != ST_LONG) begin
						nxt.err = fail_code;
					end
				end
			end
		end
	end

endmodule

[sim/tb_coordinate_frame_text_parser_top.sv]
`timescale 1ns / 100ps
// Testbench for the coordinate frame text parser: directed and random frames, a parse predictor and a result checker.
module tb_coordinate_frame_text_parser_top;
	import cfp_pkg::*;

	localparam int MaxLen = MaxFrameLenDefault;
	localparam int IdleLimit = 3000;
	localparam int BatchBytes = 725;

	typedef struct {
		status_t               status;
		logic [AccW-1:0]       az;
		logic signed [ElW-1:0] el;
		longint unsigned       stamp;
	} fix_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [7:0]            rx_byte = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [1:0]            frame_status;
	logic [AccW-1:0]       azimuth_tenths;
	logic signed [ElW-1:0] elevation_tenths;

	logic [7:0] byte_q[$];
	fix_t       fix_q[$];

	phase_t          phase;
	logic [AccW-1:0] az_sum;
	logic [AccW-1:0] el_sum;
	logic            el_minus;
	int              int_digits;
	int              byte_count;
	status_t         held_status;

	int mismatches = 0;
	int bytes_taken = 0;
	int queued = 0;
	int tx_gap = 0;
	int tx_calm = 0;
	int rx_gap = 0;
	int rx_calm = 0;
	int idle_cycles = 0;
	int hold_left;
	logic hold_done;

	coordinate_frame_text_parser_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.frame_status(frame_status),
		.azimuth_tenths(azimuth_tenths),
		.elevation_tenths(elevation_tenths)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic numeral(input logic [7:0] c);
		return (c >= ChrZero) && (c <= ChrNine);
	endfunction

	function automatic logic [AccW-1:0] times_ten_plus(input logic [AccW-1:0] sum,
			input logic [7:0] c);
		logic [7:0] d;
		d = c - ChrZero;
		return sum * 14'd10 + {6'd0, d};
	endfunction

	function automatic void clear_parse();
		phase = PH_START;
		az_sum = '0;
		el_sum = '0;
		el_minus = 1'b0;
		int_digits = 0;
		byte_count = 0;
		held_status = ST_OK;
	endfunction

	function automatic void set_error(input status_t code);
		if (held_status != ST_LONG)
			held_status = code;
		phase = PH_ERROR;
	endfunction

	function automatic void parse_rx_byte(input logic [7:0] c);
		fix_t f;
		if (c == ChrEnd) begin
			f.az = '0;
			f.el = '0;
			f.stamp = $time;
			case (phase)
				PH_END: begin
					f.status = ST_OK;
					f.az = az_sum;
					f.el = {1'b0, el_sum};
					if (el_minus)
						f.el = -f.el;
				end
				PH_ERROR: f.status = held_status;
				PH_START: f.status = ST_NOSTART;
				default: f.status = ST_BAD;
			endcase
			fix_q.push_back(f);
			clear_parse();
			return;
		end
		if (byte_count < MaxLen)
			byte_count++;
		if (byte_count >= MaxLen) begin
			held_status = ST_LONG;
			phase = PH_ERROR;
			return;
		end
		case (phase)
			PH_START: begin
				if (c == ChrStart) begin
					phase = PH_AZ_INT;
					int_digits = 0;
				end else
					set_error(ST_NOSTART);
			end
			PH_AZ_INT: begin
				if (c == ChrPoint && int_digits > 0)
					phase = PH_AZ_FRAC;
				else if (numeral(c) && int_digits < 3) begin
					az_sum = times_ten_plus(az_sum, c);
					int_digits++;
				end else
					set_error(ST_BAD);
			end
			PH_AZ_FRAC: begin
				if (numeral(c)) begin
					az_sum = times_ten_plus(az_sum, c);
					phase = PH_SEP;
				end else
					set_error(ST_BAD);
			end
			PH_SEP: begin
				if (c == ChrSpace) begin
					phase = PH_EL_INT;
					int_digits = 0;
				end else
					set_error(ST_BAD);
			end
			PH_EL_INT: begin
				if (c == ChrMinus && int_digits == 0 && !el_minus)
					el_minus = 1'b1;
				else if (c == ChrPoint && int_digits > 0)
					phase = PH_EL_FRAC;
				else if (numeral(c) && int_digits < 3) begin
					el_sum = times_ten_plus(el_sum, c);
					int_digits++;
				end else
					set_error(ST_BAD);
			end
			PH_EL_FRAC: begin
				if (numeral(c)) begin
					el_sum = times_ten_plus(el_sum, c);
					phase = PH_END;
				end else
					set_error(ST_BAD);
			end
			PH_END: set_error(ST_BAD);
			default: ;
		endcase
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		if (p < 88)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 45);
	endfunction

	function automatic logic [7:0] rand_numeral();
		return ChrZero + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_non_end();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == ChrEnd);
		return b;
	endfunction

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			byte_q.push_back(s[i]);
	endtask

	// Mostly well-formed frames, some with one corrupted, added or dropped byte,
	// a few long ones, most of them overlong, and some plain noise.
	task automatic queue_random_frame();
		logic [7:0] f[$];
		int kind;
		int n;
		int pos;
		kind = $urandom_range(0, 99);
		if (kind < 85) begin
			f.push_back(ChrStart);
			n = $urandom_range(1, 3);
			repeat (n) f.push_back(rand_numeral());
			f.push_back(ChrPoint);
			f.push_back(rand_numeral());
			f.push_back(ChrSpace);
			if ($urandom_range(0, 1))
				f.push_back(ChrMinus);
			n = $urandom_range(1, 3);
			repeat (n) f.push_back(rand_numeral());
			f.push_back(ChrPoint);
			f.push_back(rand_numeral());
			if (kind >= 55) begin
				pos = $urandom_range(0, f.size() - 1);
				case ($urandom_range(0, 4))
					0: f[pos] = 8'($urandom_range(0, 255));
					1: f.insert(pos, 8'($urandom_range(0, 255)));
					2: f.delete(pos);
					3: f.insert(pos, rand_numeral());
					default: f.insert(pos, ChrMinus);
				endcase
			end
		end else if (kind < 92) begin
			f.push_back($urandom_range(0, 3) != 0 ? ChrStart : rand_non_end());
			n = $urandom_range(28, 38);
			repeat (n) f.push_back(rand_non_end());
		end else begin
			n = $urandom_range(0, 8);
			repeat (n) f.push_back(8'($urandom_range(0, 255)));
		end
		f.push_back(ChrEnd);
		queued += f.size();
		foreach (f[i])
			byte_q.push_back(f[i]);
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (byte_q.size() != 0 || in_valid || fix_q.size() != 0);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= '0;
			clear_parse();
		end else begin
			if (in_valid && in_ready) begin
				parse_rx_byte(rx_byte);
				bytes_taken++;
			end
			if (!in_valid || in_ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (byte_q.size() != 0) begin
					in_valid <= 1'b1;
					rx_byte <= byte_q.pop_front();
					if (tx_calm > 0)
						tx_calm--;
					else begin
						if ($urandom_range(0, 99) == 0)
							tx_calm = $urandom_range(30, 150);
						tx_gap = pick_gap();
					end
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// One long stall of the result side while bytes keep coming, so that the block backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && bytes_taken >= 400) begin
			hold_left <= 400;
			hold_done <= 1'b1;
		end else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk or negedge arst_n) begin
		fix_t want;
		if (!arst_n)
			out_ready <= 1'b0;
		else begin
			if (out_valid && out_ready) begin
				if (fix_q.size() == 0 || fix_q[0].stamp >= $time) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with none expected: status %0d az %0d el %0d",
							$time, frame_status, azimuth_tenths, elevation_tenths);
				end else begin
					want = fix_q.pop_front();
					if (frame_status != want.status || azimuth_tenths != want.az
							|| elevation_tenths != want.el) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: expected status %0d az %0d el %0d, got status %0d az %0d el %0d",
								$time, want.status, want.az, want.el,
								frame_status, azimuth_tenths, elevation_tenths);
					end
				end
			end
			if (hold_left != 0)
				out_ready <= 1'b0;
			else if (rx_gap > 0) begin
				rx_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (rx_calm > 0)
					rx_calm--;
				else begin
					if ($urandom_range(0, 99) == 0)
						rx_calm = $urandom_range(30, 150);
					rx_gap = pick_gap();
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		push_text("$999.9 -999.9!");
		push_text("!");
		push_text("$0.0 -0.0!");
		wait_drained();
		queued = 0;
		while (queued < BatchBytes)
			queue_random_frame();
		wait_drained();
		queued = 0;
		while (queued < BatchBytes)
			queue_random_frame();
		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && fix_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
